/* hw/rtl/wed_pkg.sv */
// ----------------------------------------------------------------------------
// wed_pkg
// Shared types, constants and helpers of the WALE eddy viscosity pipeline.
// ----------------------------------------------------------------------------
package wed_pkg;

  localparam logic signed [63:0] Q_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] S_MAX  = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_HALF = 64'sh0000_0000_8000_0000;
  localparam logic signed [63:0] Q_EPS  = 64'sd4295;

  // pipeline depth of the arithmetic units
  localparam int MUL_LAT  = 3;
  localparam int SQRT_LAT = 24;
  localparam int DIV_LAT  = 49;

  // Q32.32 value with its sticky saturation tag
  typedef struct packed {
    logic               sat;
    logic signed [63:0] val;
  } wed_q_t;

  typedef enum logic [1:0] {
    CFG_PRANDTL = 2'd0,
    CFG_WALE    = 2'd1,
    CFG_ENERGY  = 2'd2
  } wed_cfg_e;

  function automatic logic [62:0] wed_mag(input logic signed [63:0] v);
    logic signed [63:0] n;
    n = -v;
    return v[63] ? n[62:0] : v[62:0];
  endfunction

  function automatic wed_q_t wed_add(input wed_q_t a, input wed_q_t b);
    logic signed [64:0] s;
    wed_q_t r;
    s = {a.val[63], a.val} + {b.val[63], b.val};
    r.sat = a.sat | b.sat;
    r.val = s[63:0];
    if (s > S_MAX) begin
      r.sat = 1'b1;
      r.val = Q_MAX;
    end else if (s < -S_MAX) begin
      r.sat = 1'b1;
      r.val = -Q_MAX;
    end
    return r;
  endfunction

  function automatic wed_q_t wed_neg(input wed_q_t a);
    wed_q_t r;
    r.sat = a.sat;
    r.val = -a.val;
    return r;
  endfunction

endpackage

/* hw/rtl/wed_mulq.sv */
// ----------------------------------------------------------------------------
// wed_mulq
// Three-stage Q32.32 multiplier: magnitudes, four 32x32 partial products,
// then sum, round half away from zero and saturate.
// ----------------------------------------------------------------------------
module wed_mulq import wed_pkg::*; (
  input  logic   clk_i,
  input  logic   en_i,
  input  wed_q_t a_i,
  input  wed_q_t b_i,
  output wed_q_t p_o
);

  logic          neg1_q, sat1_q, neg2_q, sat2_q;
  logic [62:0]   x_q, y_q;
  logic [63:0]   ll_q;
  logic [62:0]   lh_q, hl_q;
  logic [61:0]   hh_q;
  logic [127:0]  prod;
  logic [63:0]   mag;
  logic          big;
  logic [63:0]   mag_c;
  wed_q_t        p_d, p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= a_i.val[63] ^ b_i.val[63];
      sat1_q <= a_i.sat | b_i.sat;
      x_q    <= wed_mag(a_i.val);
      y_q    <= wed_mag(b_i.val);
      neg2_q <= neg1_q;
      sat2_q <= sat1_q;
      ll_q   <= 64'(x_q[31:0]) * 64'(y_q[31:0]);
      lh_q   <= 63'(x_q[31:0]) * 63'(y_q[62:32]);
      hl_q   <= 63'(x_q[62:32]) * 63'(y_q[31:0]);
      hh_q   <= 62'(x_q[62:32]) * 62'(y_q[62:32]);
      p_q    <= p_d;
    end
  end

  always_comb begin
    prod  = {64'b0, ll_q} + {33'b0, lh_q, 32'b0} + {33'b0, hl_q, 32'b0}
          + {2'b0, hh_q, 64'b0};
    mag   = {1'b0, prod[94:32]} + 64'(prod[31]);
    big   = (|prod[127:95]) | mag[63];
    mag_c = big ? 64'(Q_MAX) : mag;
    p_d.sat = sat2_q | big;
    p_d.val = neg2_q ? -signed'(mag_c) : signed'(mag_c);
  end

  assign p_o = p_q;

endmodule

/* hw/rtl/wed_divq.sv */
// ----------------------------------------------------------------------------
// wed_divq
// Pipelined Q32.32 restoring divider: 96 quotient bits, two per stage,
// then a rounding and saturation stage.
// ----------------------------------------------------------------------------
module wed_divq import wed_pkg::*; (
  input  logic   clk_i,
  input  logic   en_i,
  input  wed_q_t a_i,
  input  wed_q_t b_i,
  output wed_q_t q_o
);

  localparam int NSTG = DIV_LAT - 1;

  typedef struct packed {
    logic        sat;
    logic        neg;
    logic        zneg;
    logic        yz;
    logic        ovf;
    logic [63:0] n;
    logic [63:0] rem;
    logic [63:0] q;
    logic [62:0] y;
  } dv_t;

  dv_t         st_q [NSTG];
  dv_t         seed, s;
  logic        rnd, big;
  logic [64:0] qr;
  logic [63:0] mag_c;
  wed_q_t      q_d, q_q;

  function automatic dv_t dv_step(input dv_t a);
    dv_t r;
    r = a;
    for (int j = 0; j < 2; j++) begin
      r.rem = {r.rem[62:0], r.n[63]};
      r.n   = {r.n[62:0], 1'b0};
      r.ovf = r.ovf | r.q[63];
      r.q   = {r.q[62:0], 1'b0};
      if (r.rem >= {1'b0, r.y}) begin
        r.rem  = r.rem - {1'b0, r.y};
        r.q[0] = 1'b1;
      end
    end
    return r;
  endfunction

  always_comb begin
    seed.sat  = a_i.sat | b_i.sat;
    seed.neg  = a_i.val[63] ^ b_i.val[63];
    seed.zneg = a_i.val[63];
    seed.yz   = (b_i.val == '0);
    seed.ovf  = 1'b0;
    seed.n    = {1'b0, wed_mag(a_i.val)};
    seed.rem  = '0;
    seed.q    = '0;
    seed.y    = wed_mag(b_i.val);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= dv_step(seed);
      for (int k = 1; k < NSTG; k++) begin
        st_q[k] <= dv_step(st_q[k-1]);
      end
      q_q <= q_d;
    end
  end

  always_comb begin
    s     = st_q[NSTG-1];
    rnd   = s.rem >= ({1'b0, s.y} - s.rem);
    qr    = {1'b0, s.q} + 65'(rnd);
    big   = s.ovf | (qr > 65'(Q_MAX));
    mag_c = big ? 64'(Q_MAX) : qr[63:0];
    if (s.yz) begin
      q_d.sat = 1'b1;
      q_d.val = s.zneg ? -Q_MAX : Q_MAX;
    end else begin
      q_d.sat = s.sat | big;
      q_d.val = s.neg ? -signed'(mag_c) : signed'(mag_c);
    end
  end

  assign q_o = q_q;

endmodule

/* hw/rtl/wale_eddy_viscosity_2d.sv */
// ----------------------------------------------------------------------------
// wale_eddy_viscosity_2d
// WALE subfilter closure for one 2D mesh point per item. Takes one item per
// clock while the output is not stalled, one result per clock in steady
// state. The longest chain of units: multipliers of 3 stages, square roots
// of 24 stages and two dividers of 49 stages in series (WALE operator, then
// conductivity or energy quotient). A stall at the output holds the whole
// pipeline, nothing is dropped. The user must write the registers only
// while no item is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module wale_eddy_viscosity_2d import wed_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] density_i,
  input  logic [31:0] du_dx_i,
  input  logic [31:0] du_dy_i,
  input  logic [31:0] dv_dx_i,
  input  logic [31:0] dv_dy_i,
  input  logic [31:0] grid_delta_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] eddy_viscosity_o,
  output logic [31:0] thermal_conductivity_o,
  output logic [31:0] subfilter_energy_o,
  output logic        saturated_o
);

  localparam int SHIFT = 32 - FRAC_BITS;
  localparam logic [63:0] RND = 64'd1 << (SHIFT - 1);
  localparam logic [31:0] PR_RST =
    32'((64'd9 * (64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [31:0] WC_RST =
    32'((64'd325 * (64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [31:0] EC_RST =
    32'((64'd94 * (64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

  localparam int DL_G    = MUL_LAT + 1;
  localparam int DL_SS1  = MUL_LAT;
  localparam int DL_SS2  = SQRT_LAT - MUL_LAT;
  localparam int DL_SSD  = 2 * SQRT_LAT;
  localparam int DL_DEN1 = 4 + MUL_LAT + SQRT_LAT;
  localparam int DL_NUM  = 2 + SQRT_LAT;
  localparam int DL_TT   = 8 + 2 * MUL_LAT + 2 * SQRT_LAT + DIV_LAT;
  localparam int DL_RHO  = 8 + 5 * MUL_LAT + 2 * SQRT_LAT + DIV_LAT;
  localparam int DL_EFW  = 8 + 4 * MUL_LAT + 2 * SQRT_LAT + DIV_LAT;
  localparam int DL_NU   = MUL_LAT + DIV_LAT;
  localparam int PIPE_LEN = 10 + 6 * MUL_LAT + 2 * SQRT_LAT + 2 * DIV_LAT;

  localparam wed_q_t HALF_C = '{sat: 1'b0, val: Q_HALF};
  localparam wed_q_t EPS_C  = '{sat: 1'b0, val: Q_EPS};

  typedef struct packed {
    logic        sat;
    logic [63:0] x;
    logic [51:0] rem;
    logic [47:0] root;
  } sq_t;

  function automatic wed_q_t in_s(input logic [31:0] v);
    wed_q_t r;
    r.sat = 1'b0;
    r.val = signed'({{32{v[31]}}, v} << SHIFT);
    return r;
  endfunction

  function automatic wed_q_t in_u(input logic [31:0] v);
    wed_q_t r;
    r.sat = 1'b0;
    r.val = signed'({32'b0, v} << SHIFT);
    return r;
  endfunction

  function automatic logic [32:0] to_out(input logic signed [63:0] x);
    logic [63:0] r;
    r = (x <= 0) ? '0 : ((64'(x) + RND) >> SHIFT);
    if (r > 64'h0000_0000_FFFF_FFFF) begin
      return {1'b1, 32'hFFFF_FFFF};
    end
    return {1'b0, r[31:0]};
  endfunction

  function automatic sq_t sq_seed(input wed_q_t a);
    sq_t r;
    r.sat  = a.sat;
    r.x    = (a.val > 0) ? 64'(a.val) : '0;
    r.rem  = '0;
    r.root = '0;
    return r;
  endfunction

  function automatic sq_t sq_step(input sq_t a);
    sq_t r;
    logic [51:0] tr;
    r = a;
    for (int j = 0; j < 2; j++) begin
      r.rem = {r.rem[49:0], r.x[63:62]};
      r.x   = {r.x[61:0], 2'b00};
      tr    = {2'b00, r.root, 2'b01};
      if (r.rem >= tr) begin
        r.rem  = r.rem - tr;
        r.root = {r.root[46:0], 1'b1};
      end else begin
        r.root = {r.root[46:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic [31:0] pr_q, wc_q, ec_q;
  logic [PIPE_LEN-1:0] valid_q;
  logic adv;

  wed_q_t prq, wcq, ecq;
  wed_q_t a_q, b_q, c_q, d_q, rho_q, fw_q;
  wed_q_t aa, bc, ab, bd, ca, dc, dd, fwc, efw, ee, tt, hee;
  wed_q_t e_q, gxx_q, gxy_q, gyx_q, gyy_q, ss1_q, s1_q, s2_q;
  wed_q_t dv, sxy, ss_q, sxx_q, syy_q, sxx2, sxy2, syy2;
  wed_q_t p1_q, p2_q, ssd_q, ss2, den1, num, den2, den_q, dene_q;
  wed_q_t sw, nu, rn, kap, qv, k;
  wed_q_t sq_in [3];
  wed_q_t sq_out [3];
  sq_t    sq_q [3][SQRT_LAT];

  wed_q_t gxx_dl [DL_G];
  wed_q_t gyy_dl [DL_G];
  wed_q_t ss1_dl [DL_SS1];
  wed_q_t sxy2_dl [2];
  wed_q_t syy2_dl [2];
  wed_q_t ss2_dl [DL_SS2];
  wed_q_t ssd_dl [DL_SSD];
  wed_q_t den1_dl [DL_DEN1];
  wed_q_t num_dl [DL_NUM];
  wed_q_t tt_dl [DL_TT];
  wed_q_t rho_dl [DL_RHO];
  wed_q_t efw_dl [DL_EFW];
  wed_q_t nu_dl [DL_NU];

  logic [32:0] o_nu, o_kap, o_k;
  logic [31:0] eddy_q, kap_q, k_q;
  logic        sat_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_q <= PR_RST;
      wc_q <= WC_RST;
      ec_q <= EC_RST;
    end else if (cfg_valid_i) begin
      unique case (wed_cfg_e'(cfg_index_i))
        CFG_PRANDTL: pr_q <= cfg_data_i;
        CFG_WALE:    wc_q <= cfg_data_i;
        CFG_ENERGY:  ec_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign prq = in_u(pr_q);
  assign wcq = in_u(wc_q);
  assign ecq = in_u(ec_q);

  // pipeline control
  assign adv         = !valid_q[PIPE_LEN-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = valid_q[PIPE_LEN-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[PIPE_LEN-2:0], in_valid_i};
    end
  end

  // input stage and adders
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rho_q  <= in_u(density_i);
      a_q    <= in_s(du_dx_i);
      b_q    <= in_s(du_dy_i);
      c_q    <= in_s(dv_dx_i);
      d_q    <= in_s(dv_dy_i);
      fw_q   <= in_u(grid_delta_i);
      e_q    <= wed_add(b_q, c_q);
      gxx_q  <= wed_add(aa, bc);
      gxy_q  <= wed_add(ab, bd);
      gyx_q  <= wed_add(ca, dc);
      gyy_q  <= wed_add(bc, dd);
      ss1_q  <= wed_add(aa, dd);
      s1_q   <= wed_add(gxx_q, gyy_q);
      s2_q   <= wed_add(gxy_q, gyx_q);
      ss_q   <= wed_add(ss1_dl[DL_SS1-1], hee);
      sxx_q  <= wed_add(gxx_dl[DL_G-1], wed_neg(dv));
      syy_q  <= wed_add(gyy_dl[DL_G-1], wed_neg(dv));
      p1_q   <= wed_add(sxx2, sxy2_dl[0]);
      p2_q   <= wed_add(p1_q, sxy2_dl[1]);
      ssd_q  <= wed_add(p2_q, syy2_dl[1]);
      den_q  <= wed_add(den1_dl[DL_DEN1-1], den2);
      dene_q <= wed_add(den_q, EPS_C);
    end
  end

  // alignment delay lines
  always_ff @(posedge clk_i) begin
    if (adv) begin
      gxx_dl[0]  <= gxx_q;
      gyy_dl[0]  <= gyy_q;
      ss1_dl[0]  <= ss1_q;
      sxy2_dl[0] <= sxy2;
      syy2_dl[0] <= syy2;
      ss2_dl[0]  <= ss2;
      ssd_dl[0]  <= ssd_q;
      den1_dl[0] <= den1;
      num_dl[0]  <= num;
      tt_dl[0]   <= tt;
      rho_dl[0]  <= rho_q;
      efw_dl[0]  <= efw;
      nu_dl[0]   <= nu;
      for (int i = 1; i < DL_G; i++) begin
        gxx_dl[i] <= gxx_dl[i-1];
        gyy_dl[i] <= gyy_dl[i-1];
      end
      for (int i = 1; i < DL_SS1; i++) ss1_dl[i] <= ss1_dl[i-1];
      sxy2_dl[1] <= sxy2_dl[0];
      syy2_dl[1] <= syy2_dl[0];
      for (int i = 1; i < DL_SS2; i++) ss2_dl[i] <= ss2_dl[i-1];
      for (int i = 1; i < DL_SSD; i++) ssd_dl[i] <= ssd_dl[i-1];
      for (int i = 1; i < DL_DEN1; i++) den1_dl[i] <= den1_dl[i-1];
      for (int i = 1; i < DL_NUM; i++) num_dl[i] <= num_dl[i-1];
      for (int i = 1; i < DL_TT; i++) tt_dl[i] <= tt_dl[i-1];
      for (int i = 1; i < DL_RHO; i++) rho_dl[i] <= rho_dl[i-1];
      for (int i = 1; i < DL_EFW; i++) efw_dl[i] <= efw_dl[i-1];
      for (int i = 1; i < DL_NU; i++) nu_dl[i] <= nu_dl[i-1];
    end
  end

  // square roots, two result bits per stage
  assign sq_in[0] = ss_q;
  assign sq_in[1] = ssd_q;
  assign sq_in[2] = sq_out[1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int u = 0; u < 3; u++) begin
        sq_q[u][0] <= sq_step(sq_seed(sq_in[u]));
        for (int k = 1; k < SQRT_LAT; k++) begin
          sq_q[u][k] <= sq_step(sq_q[u][k-1]);
        end
      end
    end
  end

  always_comb begin
    for (int u = 0; u < 3; u++) begin
      sq_out[u].sat = sq_q[u][SQRT_LAT-1].sat;
      sq_out[u].val = signed'({16'b0, sq_q[u][SQRT_LAT-1].root});
    end
  end

  // multipliers
  wed_mulq u_aa  (.clk_i, .en_i(adv), .a_i(a_q),   .b_i(a_q),  .p_o(aa));
  wed_mulq u_bc  (.clk_i, .en_i(adv), .a_i(b_q),   .b_i(c_q),  .p_o(bc));
  wed_mulq u_ab  (.clk_i, .en_i(adv), .a_i(a_q),   .b_i(b_q),  .p_o(ab));
  wed_mulq u_bd  (.clk_i, .en_i(adv), .a_i(b_q),   .b_i(d_q),  .p_o(bd));
  wed_mulq u_ca  (.clk_i, .en_i(adv), .a_i(c_q),   .b_i(a_q),  .p_o(ca));
  wed_mulq u_dc  (.clk_i, .en_i(adv), .a_i(d_q),   .b_i(c_q),  .p_o(dc));
  wed_mulq u_dd  (.clk_i, .en_i(adv), .a_i(d_q),   .b_i(d_q),  .p_o(dd));
  wed_mulq u_fwc (.clk_i, .en_i(adv), .a_i(fw_q),  .b_i(wcq),  .p_o(fwc));
  wed_mulq u_efw (.clk_i, .en_i(adv), .a_i(ecq),   .b_i(fw_q), .p_o(efw));
  wed_mulq u_ee  (.clk_i, .en_i(adv), .a_i(e_q),   .b_i(e_q),  .p_o(ee));
  wed_mulq u_tt  (.clk_i, .en_i(adv), .a_i(fwc),   .b_i(fwc),  .p_o(tt));
  wed_mulq u_hee (.clk_i, .en_i(adv), .a_i(HALF_C), .b_i(ee),  .p_o(hee));
  wed_mulq u_dv  (.clk_i, .en_i(adv), .a_i(HALF_C), .b_i(s1_q), .p_o(dv));
  wed_mulq u_sxy (.clk_i, .en_i(adv), .a_i(HALF_C), .b_i(s2_q), .p_o(sxy));
  wed_mulq u_sxx2 (.clk_i, .en_i(adv), .a_i(sxx_q), .b_i(sxx_q), .p_o(sxx2));
  wed_mulq u_sxy2 (.clk_i, .en_i(adv), .a_i(sxy),   .b_i(sxy),   .p_o(sxy2));
  wed_mulq u_syy2 (.clk_i, .en_i(adv), .a_i(syy_q), .b_i(syy_q), .p_o(syy2));
  wed_mulq u_ss2 (.clk_i, .en_i(adv), .a_i(ss_q), .b_i(ss_q), .p_o(ss2));
  wed_mulq u_den1 (.clk_i, .en_i(adv), .a_i(ss2_dl[DL_SS2-1]), .b_i(sq_out[0]),
                   .p_o(den1));
  wed_mulq u_num (.clk_i, .en_i(adv), .a_i(ssd_dl[SQRT_LAT-1]), .b_i(sq_out[1]),
                  .p_o(num));
  wed_mulq u_den2 (.clk_i, .en_i(adv), .a_i(ssd_dl[DL_SSD-1]), .b_i(sq_out[2]),
                   .p_o(den2));
  wed_mulq u_nu  (.clk_i, .en_i(adv), .a_i(tt_dl[DL_TT-1]), .b_i(sw), .p_o(nu));
  wed_mulq u_rn  (.clk_i, .en_i(adv), .a_i(rho_dl[DL_RHO-1]), .b_i(nu), .p_o(rn));
  wed_mulq u_k   (.clk_i, .en_i(adv), .a_i(qv), .b_i(qv), .p_o(k));

  // dividers
  wed_divq u_sw  (.clk_i, .en_i(adv), .a_i(num_dl[DL_NUM-1]), .b_i(dene_q),
                  .q_o(sw));
  wed_divq u_kap (.clk_i, .en_i(adv), .a_i(rn), .b_i(prq), .q_o(kap));
  wed_divq u_q   (.clk_i, .en_i(adv), .a_i(nu), .b_i(efw_dl[DL_EFW-1]), .q_o(qv));

  // output stage
  assign o_nu  = to_out(nu_dl[DL_NU-1].val);
  assign o_kap = to_out(kap.val);
  assign o_k   = to_out(k.val);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      eddy_q <= o_nu[31:0];
      kap_q  <= o_kap[31:0];
      k_q    <= o_k[31:0];
      sat_q  <= nu_dl[DL_NU-1].sat | kap.sat | k.sat | o_nu[32] | o_kap[32] | o_k[32];
    end
  end

  assign eddy_viscosity_o       = eddy_q;
  assign thermal_conductivity_o = kap_q;
  assign subfilter_energy_o     = k_q;
  assign saturated_o            = sat_q;

endmodule

/* hw/rtl/wed_checker.sv */
// ----------------------------------------------------------------------------
// wed_checker
// Port-level checks of the WALE eddy viscosity block, bound to the top level.
// ----------------------------------------------------------------------------
module wed_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] eddy_viscosity_o,
  input logic [31:0] thermal_conductivity_o,
  input logic [31:0] subfilter_energy_o,
  input logic        saturated_o
);

  logic [7:0] cnt_q, cnt_d;

  // items in flight
  always_comb begin
    cnt_d = cnt_q + 8'(in_valid_i && in_ready_o) - 8'(out_valid_o && out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(eddy_viscosity_o)
      && $stable(thermal_conductivity_o) && $stable(subfilter_energy_o)
      && $stable(saturated_o))
    else $error("result changed while stalled");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without an output stall");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != 8'd0)
    else $error("result without an accepted item");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no pending result");

endmodule

bind wale_eddy_viscosity_2d wed_checker u_wed_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .in_valid_i             (in_valid_i),
  .in_ready_o             (in_ready_o),
  .out_valid_o            (out_valid_o),
  .out_ready_i            (out_ready_i),
  .eddy_viscosity_o       (eddy_viscosity_o),
  .thermal_conductivity_o (thermal_conductivity_o),
  .subfilter_energy_o     (subfilter_energy_o),
  .saturated_o            (saturated_o)
);

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for wale_eddy_viscosity_2d. Mesh points are sent over
// the valid/ready input with random gaps, results are drawn with random
// stalls and one long hold-off, and every result is checked field by field
// against a bit-exact Q32.32 model of the WALE closure kept in the bench.
// Register settings cover the reset values and the range extremes.
// ----------------------------------------------------------------------------
module tb;
  import wed_pkg::*;

  localparam int SH        = 16;
  localparam int LATENCY   = 174;
  localparam int LIMIT     = 600000;
  localparam logic [63:0] QMAXU = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] nu;
    logic [31:0] kappa;
    logic [31:0] energy;
    logic        sat;
  } visc_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_PRANDTL;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] density = '0, du_dx = '0, du_dy = '0, dv_dx = '0, dv_dy = '0;
  logic [31:0] grid_delta = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] eddy_viscosity, thermal_conductivity, subfilter_energy;
  logic        saturated;

  logic [31:0] prandtl_reg, wale_reg, energy_reg;
  bit          sat_flag;
  visc_res_t   visc_q[$];
  int          err_count = 0;
  int          cycles = 0;
  bit          tx_fast = 0, rx_fast = 0;
  int          hold_cycles = 0;

  wale_eddy_viscosity_2d u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .density_i(density), .du_dx_i(du_dx), .du_dy_i(du_dy),
    .dv_dx_i(dv_dx), .dv_dy_i(dv_dy), .grid_delta_i(grid_delta),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .eddy_viscosity_o(eddy_viscosity),
    .thermal_conductivity_o(thermal_conductivity),
    .subfilter_energy_o(subfilter_energy), .saturated_o(saturated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // fixed-point model of the closure

  function automatic logic [63:0] q_mag(input logic signed [63:0] a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] q_make(input bit neg, input logic [127:0] m);
    logic [63:0] t;
    if (m > 128'(QMAXU)) begin
      sat_flag = 1;
      m = 128'(QMAXU);
    end
    t = m[63:0];
    return neg ? 64'(-t) : t;
  endfunction

  function automatic logic signed [63:0] q_add(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > $signed({1'b0, QMAXU})) begin
      sat_flag = 1;
      return QMAXU;
    end
    if (s < -$signed({1'b0, QMAXU})) begin
      sat_flag = 1;
      return 64'(-QMAXU);
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    bit neg;
    logic [127:0] p;
    neg = (a < 0) != (b < 0);
    p = 128'(q_mag(a)) * 128'(q_mag(b));
    if (p[127:95] != 0) begin
      sat_flag = 1;
      return q_make(neg, 128'(QMAXU));
    end
    return q_make(neg, 128'(p[95:32]) + 128'(p[31]));
  endfunction

  function automatic logic signed [63:0] q_div(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    bit neg;
    logic [127:0] y, num, qt, rem;
    neg = (a < 0) != (b < 0);
    y = 128'(q_mag(b));
    if (y == 0) begin
      sat_flag = 1;
      return q_make(a < 0, 128'(QMAXU));
    end
    num = 128'(q_mag(a)) << 32;
    qt = num / y;
    rem = num % y;
    if (qt[127:64] != 0) begin
      sat_flag = 1;
      return q_make(neg, 128'(QMAXU));
    end
    if (rem >= y - rem) begin
      if (qt == 128'(64'hFFFF_FFFF_FFFF_FFFF)) begin
        sat_flag = 1;
        return q_make(neg, 128'(QMAXU));
      end
      qt = qt + 1;
    end
    return q_make(neg, qt);
  endfunction

  function automatic logic signed [63:0] q_sqrt(input logic signed [63:0] a);
    logic [127:0] n, root, cand;
    if (a <= 0) return 0;
    n = 128'(a) << 32;
    root = 0;
    for (int i = 47; i >= 0; i--) begin
      cand = root | (128'(1) << i);
      if (cand * cand <= n) root = cand;
    end
    return root[63:0];
  endfunction

  function automatic logic signed [63:0] q_in_s(input logic [31:0] v);
    if (v[31]) return q_make(1, (128'(33'h1_0000_0000) - 128'(v)) << SH);
    return q_make(0, 128'(v) << SH);
  endfunction

  function automatic logic signed [63:0] q_in_u(input logic [31:0] v);
    return q_make(0, 128'(v) << SH);
  endfunction

  function automatic logic [31:0] q_out(input logic signed [63:0] x);
    logic [63:0] r;
    if (x <= 0) return 0;
    r = (64'(x) + (64'(1) << (SH - 1))) >> SH;
    if (r > 64'hFFFF_FFFF) begin
      sat_flag = 1;
      r = 64'hFFFF_FFFF;
    end
    return r[31:0];
  endfunction

  function automatic visc_res_t predict_point(input logic [31:0] rho_w, ux_w, uy_w,
                                              vx_w, vy_w, fw_w);
    logic signed [63:0] rho, a, b, c, d, fw, gxx, gxy, gyx, gyy, dv, sxx, sxy, syy;
    logic signed [63:0] ssd, e, ss, rs, num, den, sw, t, nu, kap, q, k;
    visc_res_t r;
    sat_flag = 0;
    rho = q_in_u(rho_w);
    a = q_in_s(ux_w);
    b = q_in_s(uy_w);
    c = q_in_s(vx_w);
    d = q_in_s(vy_w);
    fw = q_in_u(fw_w);
    gxx = q_add(q_mul(a, a), q_mul(b, c));
    gxy = q_add(q_mul(a, b), q_mul(b, d));
    gyx = q_add(q_mul(c, a), q_mul(d, c));
    gyy = q_add(q_mul(c, b), q_mul(d, d));
    dv = q_mul(Q_HALF, q_add(gxx, gyy));
    sxx = q_add(gxx, -dv);
    syy = q_add(gyy, -dv);
    sxy = q_mul(Q_HALF, q_add(gxy, gyx));
    ssd = q_add(q_mul(sxx, sxx), q_mul(sxy, sxy));
    ssd = q_add(ssd, q_mul(sxy, sxy));
    ssd = q_add(ssd, q_mul(syy, syy));
    e = q_add(b, c);
    ss = q_add(q_add(q_mul(a, a), q_mul(d, d)), q_mul(Q_HALF, q_mul(e, e)));
    rs = q_sqrt(ssd);
    num = q_mul(ssd, rs);
    den = q_mul(q_mul(ss, ss), q_sqrt(ss));
    den = q_add(den, q_mul(ssd, q_sqrt(rs)));
    den = q_add(den, Q_EPS);
    sw = q_div(num, den);
    t = q_mul(fw, q_in_u(wale_reg));
    nu = q_mul(q_mul(t, t), sw);
    kap = q_div(q_mul(rho, nu), q_in_u(prandtl_reg));
    q = q_div(nu, q_mul(q_in_u(energy_reg), fw));
    k = q_mul(q, q);
    r.nu = q_out(nu);
    r.kappa = q_out(kap);
    r.energy = q_out(k);
    r.sat = sat_flag;
    return r;
  endfunction

  // stimulus side

  task automatic send_point(input logic [31:0] rho_w, ux_w, uy_w, vx_w, vy_w, fw_w);
    int gap;
    visc_res_t exp_r;
    gap = tx_fast ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    exp_r = predict_point(rho_w, ux_w, uy_w, vx_w, vy_w, fw_w);
    in_valid <= 1'b1;
    density <= rho_w;
    du_dx <= ux_w;
    du_dy <= uy_w;
    dv_dx <= vx_w;
    dv_dy <= vy_w;
    grid_delta <= fw_w;
    do @(posedge clk); while (!in_ready);
    visc_q.push_back(exp_r);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (visc_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 26) @(posedge clk);
  endtask

  task automatic write_reg(input wed_cfg_e idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PRANDTL: prandtl_reg = val;
      CFG_WALE:    wale_reg = val;
      default:     energy_reg = val;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] pr, input logic [31:0] wc,
                          input logic [31:0] ec);
    write_reg(CFG_PRANDTL, pr);
    write_reg(CFG_WALE, wc);
    write_reg(CFG_ENERGY, ec);
  endtask

  function automatic logic [31:0] small_grad(input int span);
    logic [31:0] m;
    m = $urandom_range(0, span);
    return $urandom_range(0, 1) ? 32'(-m) : m;
  endfunction

  task automatic send_random_point();
    int kind;
    logic [31:0] w[6];
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      w[0] = $urandom_range(0, 32'h0010_0000);
      for (int i = 1; i < 5; i++) w[i] = small_grad(32'h0008_0000);
      w[5] = $urandom_range(1, 32'h0004_0000);
    end else if (kind <= 7) begin
      for (int i = 0; i < 6; i++) w[i] = $urandom;
    end else if (kind == 8) begin
      for (int i = 0; i < 6; i++)
        w[i] = $urandom_range(0, 1) ? $urandom : small_grad(32'h0000_4000);
    end else begin
      w[0] = $urandom;
      for (int i = 1; i < 5; i++) w[i] = small_grad(32'h0100_0000);
      w[5] = $urandom_range(0, 1) ? 32'h0 : $urandom;
    end
    send_point(w[0], w[1], w[2], w[3], w[4], w[5]);
  endtask

  // result side

  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      n = rx_fast ? 0 : $urandom_range(0, 14);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    visc_res_t exp_r, got;
    if (rst_n && out_valid && out_ready) begin
      got = '{eddy_viscosity, thermal_conductivity, subfilter_energy, saturated};
      if (visc_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result item %p", got);
      end else begin
        exp_r = visc_q.pop_front();
        if (got !== exp_r) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: nu exp %h got %h, kappa exp %h got %h, k exp %h got %h, sat exp %b got %b",
                     exp_r.nu, got.nu, exp_r.kappa, got.kappa,
                     exp_r.energy, got.energy, exp_r.sat, got.sat);
        end
      end
    end
  end

  // tests

  task automatic test_directed();
    send_point(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_point(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000,
               32'hFFFF_0000, 32'h0000_8000);
    send_point(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'hFFFF_FFFF);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
               32'h0001_0000, 32'h0000_0000);
    send_point(32'h0002_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000,
               32'h0000_0000, 32'h0001_0000);
    send_point(32'h0002_0000, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF,
               32'h0000_0001, 32'h0001_0000);
    send_point(32'hFFFF_FFFF, 32'h0003_0000, 32'hFFFD_0000, 32'h0005_0000,
               32'h0002_0000, 32'h0000_0001);
    send_point(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h0001_0000);
    send_point(32'h8000_0000, 32'h0000_4000, 32'h0001_8000, 32'hFFFE_8000,
               32'h0000_2000, 32'h0010_0000);
    send_point(32'h0000_0001, 32'h00FF_0000, 32'h0000_0100, 32'hFF00_0000,
               32'h0000_0100, 32'h8000_0000);
    idle_input();
    wait_drained();
  endtask

  task automatic test_reg_extremes();
    set_regs(32'h1, 32'hFFFF_FFFF, 32'h1);
    repeat (20) send_random_point();
    idle_input();
    wait_drained();
    set_regs(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    repeat (20) send_random_point();
    idle_input();
    wait_drained();
  endtask

  task automatic test_random();
    logic [31:0] prs[4] = '{32'd58982, 32'h0001_0000, 32'h0000_0100, 32'h0100_0000};
    logic [31:0] wcs[4] = '{32'd21299, 32'h0000_8000, 32'h0004_0000, 32'h0000_0010};
    logic [31:0] ecs[4] = '{32'd6160, 32'h0001_0000, 32'h0000_0040, 32'h0010_0000};
    for (int s = 0; s < 4; s++) begin
      set_regs(prs[s], wcs[s], ecs[s]);
      for (int i = 0; i < 212; i++) begin
        if (i % 50 == 0) begin
          tx_fast = ($urandom_range(0, 3) == 0);
          rx_fast = ($urandom_range(0, 3) == 0);
        end
        send_random_point();
      end
      idle_input();
      tx_fast = 0;
      rx_fast = 0;
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    set_regs(32'd58982, 32'd21299, 32'd6160);
    tx_fast = 1;
    hold_cycles = 500;
    repeat (300) send_random_point();
    idle_input();
    tx_fast = 0;
    wait_drained();
  endtask

  initial begin
    prandtl_reg = 32'd58982;
    wale_reg = 32'd21299;
    energy_reg = 32'd6160;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_directed();
    test_reg_extremes();
    test_random();
    test_backpressure();
    if (err_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
